@@ rtl/ctc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctc_pkg: shared types and constants for the countdown timer controller
// Mode codes, configuration register indexes, reset values and the beat
// structures passed between the controller's modules.
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [31:0] MS_PER_MINUTE = 32'd60000;

  typedef enum logic [1:0] {
    MODE_SELECT   = 2'd0,
    MODE_RUNNING  = 2'd1,
    MODE_PAUSED   = 2'd2,
    MODE_FINISHED = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEGATIVE_KNOB    = 3'd0,
    CFG_BLINK_ON_MS      = 3'd1,
    CFG_BLINK_OFF_MS     = 3'd2,
    CFG_BEEP_LENGTH_MS   = 3'd3,
    CFG_BEEP_ON_INPUT    = 3'd4
  } cfg_idx_e;

  localparam logic        RST_NEGATIVE_KNOB    = 1'b0;
  localparam logic [15:0] RST_BLINK_ON_MS      = 16'd500;
  localparam logic [15:0] RST_BLINK_OFF_MS     = 16'd500;
  localparam logic [13:0] RST_BEEP_LENGTH_MS   = 14'd50;
  localparam logic        RST_BEEP_ON_INPUT    = 1'b1;

  typedef struct packed {
    logic        negative_knob;
    logic [15:0] blink_on_ms;
    logic [15:0] blink_off_ms;
    logic [13:0] beep_length_ms;
    logic        beep_on_input;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] knob_position;
    logic        button_released;
  } tick_t;

  typedef struct packed {
    mode_e       mode;
    logic        blink_phase;
    logic [15:0] beep_ms;
    logic        display_refresh;
    logic        clear_knob;
    logic        restarted;
    logic [15:0] selected_position;
    logic [31:0] remaining_ms;
  } result_t;

endpackage

@@ rtl/ctc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ctc_cfg_regs: configuration register file
// Holds the five settings; a restart of the timer returns them to reset.
// ----------------------------------------------------------------------------
module ctc_cfg_regs
  import ctc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                restart_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  cfg_t cfg_rst;

  assign cfg_rst = '{
    negative_knob:    RST_NEGATIVE_KNOB,
    blink_on_ms:      RST_BLINK_ON_MS,
    blink_off_ms:     RST_BLINK_OFF_MS,
    beep_length_ms:   RST_BEEP_LENGTH_MS,
    beep_on_input:    RST_BEEP_ON_INPUT
  };

  always_comb begin
    cfg_d = cfg_q;
    if (restart_i) begin
      cfg_d = cfg_rst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_NEGATIVE_KNOB:    cfg_d.negative_knob    = cfg_data_i[0];
        CFG_BLINK_ON_MS:      cfg_d.blink_on_ms      = cfg_data_i;
        CFG_BLINK_OFF_MS:     cfg_d.blink_off_ms     = cfg_data_i;
        CFG_BEEP_LENGTH_MS:   cfg_d.beep_length_ms   = cfg_data_i[13:0];
        CFG_BEEP_ON_INPUT:    cfg_d.beep_on_input    = cfg_data_i[0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfg_rst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/ctc_engine.sv @@
// ----------------------------------------------------------------------------
// ctc_engine: timer state and per-tick step logic
// Applies one tick to the timer state and forms its result.
// ----------------------------------------------------------------------------
module ctc_engine
  import ctc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  tick_t   tick_i,
  input  cfg_t    cfg_i,
  output result_t result_o,
  output logic    restart_o
);

  mode_e       mode_q, mode_d;
  logic [15:0] last_pos_q, last_pos_d;
  logic        blink_q, blink_d;
  logic [31:0] last_toggle_q, last_toggle_d;
  logic [31:0] end_q, end_d;
  logic [31:0] paused_left_q, paused_left_d;
  logic        press_seen_q, press_seen_d;
  logic        await_rel_q, await_rel_d;

  mode_e       mode_0;
  logic        knob_chg, knob_neg, knob_pos, knob_bad;
  logic [15:0] period;
  logic [31:0] since_toggle;
  logic        toggle;
  logic [15:0] magnitude;
  logic [31:0] run_ms;
  logic        restart;
  logic [15:0] beep;
  logic        refresh, clear;
  logic [31:0] remaining;
  logic [1:0]  remain_sel;

  localparam logic [1:0] RemainLive   = 2'd0;
  localparam logic [1:0] RemainStart  = 2'd1;
  localparam logic [1:0] RemainResume = 2'd2;

  assign knob_neg = tick_i.knob_position[15];
  assign knob_pos = !knob_neg && (tick_i.knob_position != '0);
  assign knob_bad = cfg_i.negative_knob ? knob_pos : knob_neg;

  assign period       = blink_q ? cfg_i.blink_on_ms : cfg_i.blink_off_ms;
  assign since_toggle = tick_i.now_ms - last_toggle_q;

  // minutes times the constant; -32768 wraps to 32768, which fits 16 bits
  assign magnitude = last_pos_d[15] ? 16'(-last_pos_d) : last_pos_d;
  assign run_ms    = {16'd0, magnitude} * MS_PER_MINUTE;

  always_comb begin
    mode_d        = mode_q;
    last_pos_d    = last_pos_q;
    blink_d       = blink_q;
    last_toggle_d = last_toggle_q;
    end_d         = end_q;
    paused_left_d = paused_left_q;
    press_seen_d  = press_seen_q;
    await_rel_d   = await_rel_q;
    beep          = '0;
    refresh       = 1'b0;
    clear         = 1'b0;
    restart       = 1'b0;
    remain_sel    = RemainLive;
    knob_chg      = tick_i.button_released && (last_pos_q != tick_i.knob_position);
    toggle        = since_toggle >= {16'd0, period};

    mode_0 = mode_q;
    if (mode_q == MODE_RUNNING && tick_i.now_ms > end_q) begin
      mode_0 = MODE_FINISHED;
    end
    mode_d = mode_0;

    if (knob_chg) begin
      last_pos_d = knob_bad ? '0 : tick_i.knob_position;
      clear      = knob_bad;
      refresh    = 1'b1;
      if (cfg_i.beep_on_input) begin
        beep = {2'b00, cfg_i.beep_length_ms};
      end
    end

    if (toggle) begin
      blink_d       = !blink_q;
      last_toggle_d = tick_i.now_ms;
      refresh       = 1'b1;
      if (!blink_q && mode_0 == MODE_FINISHED) begin
        beep = {cfg_i.beep_length_ms, 2'b00};
      end
    end

    if (tick_i.button_released) begin
      if (await_rel_q) begin
        await_rel_d  = 1'b0;
        press_seen_d = 1'b0;
      end else if (press_seen_q) begin
        case (mode_0)
          MODE_SELECT: begin
            if (last_pos_d != '0) begin
              end_d      = tick_i.now_ms + run_ms;
              mode_d     = MODE_RUNNING;
              remain_sel = RemainStart;
            end
          end
          MODE_RUNNING: begin
            paused_left_d = end_q - tick_i.now_ms;
            mode_d        = MODE_PAUSED;
          end
          MODE_PAUSED: begin
            if (last_pos_d[0]) begin
              restart = 1'b1;
            end else begin
              end_d      = tick_i.now_ms + paused_left_q;
              mode_d     = MODE_RUNNING;
              remain_sel = RemainResume;
            end
          end
          default: restart = 1'b1;
        endcase
        clear         = 1'b1;
        last_toggle_d = tick_i.now_ms;
        blink_d       = 1'b1;
        refresh       = 1'b1;
        await_rel_d   = 1'b1;
      end
    end else begin
      if (cfg_i.beep_on_input && !press_seen_q) begin
        beep = {2'b00, cfg_i.beep_length_ms};
      end
      press_seen_d = 1'b1;
    end

    // drop everything back to reset on a restart
    if (restart) begin
      mode_d        = MODE_SELECT;
      last_pos_d    = '0;
      blink_d       = 1'b0;
      last_toggle_d = '0;
      end_d         = '0;
      paused_left_d = '0;
      press_seen_d  = 1'b0;
      await_rel_d   = 1'b0;
    end
  end

  // remainder without chaining the end-time adder into a second subtract
  always_comb begin
    case (mode_d)
      MODE_RUNNING: begin
        case (remain_sel)
          RemainStart:  remaining = run_ms;
          RemainResume: remaining = paused_left_q;
          default:      remaining = end_q - tick_i.now_ms;
        endcase
      end
      MODE_PAUSED: remaining = paused_left_d;
      default:     remaining = '0;
    endcase
  end

  always_comb begin
    result_o.mode              = mode_d;
    result_o.blink_phase       = blink_d;
    result_o.beep_ms           = restart ? '0 : beep;
    result_o.display_refresh   = refresh;
    result_o.clear_knob        = clear;
    result_o.restarted         = restart;
    result_o.selected_position = last_pos_d;
    result_o.remaining_ms      = remaining;
  end

  assign restart_o = step_i && restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_SELECT;
      last_pos_q    <= '0;
      blink_q       <= 1'b0;
      last_toggle_q <= '0;
      end_q         <= '0;
      paused_left_q <= '0;
      press_seen_q  <= 1'b0;
      await_rel_q   <= 1'b0;
    end else if (step_i) begin
      mode_q        <= mode_d;
      last_pos_q    <= last_pos_d;
      blink_q       <= blink_d;
      last_toggle_q <= last_toggle_d;
      end_q         <= end_d;
      paused_left_q <= paused_left_d;
      press_seen_q  <= press_seen_d;
      await_rel_q   <= await_rel_d;
    end
  end

endmodule

@@ rtl/countdown_timer_controller.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_controller: knob and button driven countdown timer
// Input register, step logic and result register.
// ----------------------------------------------------------------------------
// Each input beat is one poll tick and yields exactly one result beat. A tick
// is captured in an input register, applied to the timer state by the step
// logic and lands in a result register. While the output is not stalled, one
// tick can be taken every cycle; the step logic holds one 16x16 constant
// multiply plus the end-time add. A result waiting under stall does not block
// the next tick from entering an empty input register, but a tick already
// held there waits and stalls the input. Write configuration only while no
// tick is in flight; a restart by the button returns the settings to their
// reset values.
module countdown_timer_controller
  import ctc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [31:0]         now_ms_i,
  input  logic signed [15:0]  knob_position_i,
  input  logic                button_released_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          mode_o,
  output logic                blink_phase_o,
  output logic [15:0]         beep_ms_o,
  output logic                display_refresh_o,
  output logic                clear_knob_o,
  output logic                restarted_o,
  output logic signed [15:0]  selected_position_o,
  output logic [31:0]         remaining_ms_o
);

  logic    in_valid_q, in_valid_d;
  tick_t   tick_q;
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  logic    accept, advance, restart;
  cfg_t    cfg;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tick_q.now_ms          <= now_ms_i;
      tick_q.knob_position   <= knob_position_i;
      tick_q.button_released <= button_released_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  ctc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .restart_i   (restart),
    .cfg_o       (cfg)
  );

  ctc_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .tick_i    (tick_q),
    .cfg_i     (cfg),
    .result_o  (res_d),
    .restart_o (restart)
  );

  assign out_valid_o         = out_valid_q;
  assign mode_o              = res_q.mode;
  assign blink_phase_o       = res_q.blink_phase;
  assign beep_ms_o           = res_q.beep_ms;
  assign display_refresh_o   = res_q.display_refresh;
  assign clear_knob_o        = res_q.clear_knob;
  assign restarted_o         = res_q.restarted;
  assign selected_position_o = res_q.selected_position;
  assign remaining_ms_o      = res_q.remaining_ms;

endmodule

@@ rtl/ctc_checker.sv @@
// ----------------------------------------------------------------------------
// ctc_checker: port-level checks for the countdown timer controller
// Watches the result channel and the fields that must agree within a beat.
// ----------------------------------------------------------------------------
module ctc_checker
  import ctc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [1:0]          mode_o,
  input logic                blink_phase_o,
  input logic [15:0]         beep_ms_o,
  input logic                display_refresh_o,
  input logic                clear_knob_o,
  input logic                restarted_o,
  input logic signed [15:0]  selected_position_o,
  input logic [31:0]         remaining_ms_o
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o)
      && $stable(remaining_ms_o) && $stable(selected_position_o))
    else $error("stalled result beat changed");

  a_restart_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && restarted_o |-> mode_o == MODE_SELECT && !blink_phase_o
      && beep_ms_o == '0 && display_refresh_o && clear_knob_o
      && selected_position_o == '0 && remaining_ms_o == '0)
    else $error("restart beat does not show the reset state");

  a_idle_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == MODE_SELECT || mode_o == MODE_FINISHED)
      |-> remaining_ms_o == '0)
    else $error("remaining time outside running or paused");

  a_clear_redraw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_knob_o |-> display_refresh_o)
    else $error("knob clear without redraw");

endmodule

bind countdown_timer_controller ctc_checker u_ctc_checker (.*);
